>>> src/rsi_pkg.sv
// Shared constants and types for the ray/sphere intersection unit.
// No dependencies.
package rsi_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int MAT_W     = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 3'd0,
    CFG_CENTER_Y = 3'd1,
    CFG_CENTER_Z = 3'd2,
    CFG_RADIUS   = 3'd3,
    CFG_MATERIAL = 3'd4
  } cfg_idx_e;

endpackage

>>> src/rsi_sqrt_cell.sv
// One digit-by-digit square root cell: resolves one root bit per cycle while en_i is high.
// Standalone; chained by the top level.
module rsi_sqrt_cell #(
  parameter int RW = 66,
  parameter int SW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [RW+1:0]     rem_i,
  input  logic [2*RW-1:0]   rad_i,
  input  logic [RW-1:0]     root_i,
  input  logic [SW-1:0]     side_i,
  output logic              valid_o,
  output logic [RW+1:0]     rem_o,
  output logic [2*RW-1:0]   rad_o,
  output logic [RW-1:0]     root_o,
  output logic [SW-1:0]     side_o
);

  logic [RW+3:0] cur;
  logic [RW+3:0] trial;
  logic [RW+3:0] diff;
  logic          take;
  logic          valid_q;
  logic [RW+1:0] rem_q;
  logic [2*RW-1:0] rad_q;
  logic [RW-1:0] root_q;
  logic [SW-1:0] side_q;

  always_comb begin
    cur   = {rem_i, rad_i[2*RW-1 -: 2]};
    trial = {2'b00, root_i, 2'b01};
    take  = cur >= trial;
    diff  = cur - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= take ? diff[RW+1:0] : cur[RW+1:0];
      root_q <= {root_i[RW-2:0], take};
      rad_q  <= {rad_i[2*RW-3:0], 2'b00};
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign rad_o   = rad_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

>>> src/rsi_div_cell.sv
// One restoring division cell: one quotient bit per lane per cycle while en_i is high.
// Standalone; chained by rsi_div_chain.
module rsi_div_cell #(
  parameter int LANES = 2,
  parameter int NW    = 84,
  parameter int DW    = 64,
  parameter int SW    = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [LANES-1:0][DW-1:0]     rem_i,
  input  logic [LANES-1:0][NW-1:0]     num_i,
  input  logic [DW-1:0]                den_i,
  input  logic [SW-1:0]                side_i,
  output logic                         valid_o,
  output logic [LANES-1:0][DW-1:0]     rem_o,
  output logic [LANES-1:0][NW-1:0]     num_o,
  output logic [DW-1:0]                den_o,
  output logic [SW-1:0]                side_o
);

  logic [LANES-1:0][DW:0]   cur;
  logic [LANES-1:0][DW:0]   diff;
  logic [LANES-1:0]         take;
  logic                     valid_q;
  logic [LANES-1:0][DW-1:0] rem_q;
  logic [LANES-1:0][NW-1:0] num_q;
  logic [DW-1:0]            den_q;
  logic [SW-1:0]            side_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      cur[l]  = {rem_i[l], num_i[l][NW-1]};
      take[l] = cur[l] >= {1'b0, den_i};
      diff[l] = cur[l] - {1'b0, den_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        rem_q[l] <= take[l] ? diff[l][DW-1:0] : cur[l][DW-1:0];
        num_q[l] <= {num_i[l][NW-2:0], take[l]};
      end
      den_q  <= den_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign side_o  = side_q;

endmodule

>>> src/rsi_div_chain.sv
// Row of division cells giving floor(num / den) for signed num, den > 0.
// Depends on rsi_div_cell.
module rsi_div_chain #(
  parameter int LANES = 2,
  parameter int NW    = 84,
  parameter int DW    = 64,
  parameter int SW    = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [LANES-1:0][NW-1:0]  num_i,
  input  logic [DW-1:0]             den_i,
  input  logic [SW-1:0]             side_i,
  output logic                      valid_o,
  output logic [LANES-1:0][NW:0]    quo_o,
  output logic [SW-1:0]             side_o
);

  localparam int XW = LANES + SW;

  logic                     c_valid [NW+1];
  logic [LANES-1:0][DW-1:0] c_rem   [NW+1];
  logic [LANES-1:0][NW-1:0] c_num   [NW+1];
  logic [DW-1:0]            c_den   [NW+1];
  logic [XW-1:0]            c_side  [NW+1];
  logic [LANES-1:0]         neg_in;
  logic [LANES-1:0]         neg_out;
  logic [LANES-1:0][NW-1:0] num_abs;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      neg_in[l]  = num_i[l][NW-1];
      num_abs[l] = neg_in[l] ? (~num_i[l] + NW'(1)) : num_i[l];
    end
  end

  assign c_num[0]   = num_abs;
  assign c_valid[0] = valid_i;
  assign c_rem[0]   = '0;
  assign c_den[0]   = den_i;
  assign c_side[0]  = {neg_in, side_i};

  for (genvar k = 0; k < NW; k++) begin : g_cell
    rsi_div_cell #(
      .LANES(LANES), .NW(NW), .DW(DW), .SW(XW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .valid_i(c_valid[k]),
      .rem_i  (c_rem[k]),
      .num_i  (c_num[k]),
      .den_i  (c_den[k]),
      .side_i (c_side[k]),
      .valid_o(c_valid[k+1]),
      .rem_o  (c_rem[k+1]),
      .num_o  (c_num[k+1]),
      .den_o  (c_den[k+1]),
      .side_o (c_side[k+1])
    );
  end

  assign neg_out = c_side[NW][XW-1:SW];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (neg_out[l]) begin
        quo_o[l] = ~{1'b0, c_num[NW][l]} + (NW+1)'(c_rem[NW][l] == '0);
      end else begin
        quo_o[l] = {1'b0, c_num[NW][l]};
      end
    end
  end

  assign valid_o = c_valid[NW];
  assign side_o  = c_side[NW][SW-1:0];

endmodule

>>> src/ray_sphere_intersect_top.sv
// Ray/sphere intersection, fully pipelined, one ray per cycle unless the output stalls.
// Pipe: front stages for the discriminant, square root row, root divider row, root pick,
// hit point, normal divider row, output register; defaults give Q16.16 coordinates.
// Throughput: one transaction per cycle; the whole pipe holds while a result waits.
// Reset: async active low; clears valids, center 0, radius 1.0, material 0.
// Depends on rsi_pkg, rsi_sqrt_cell, rsi_div_chain.
module ray_sphere_intersect_top #(
  parameter int FRAC_BITS  = 16,
  parameter int COORD_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [COORD_BITS-1:0]          cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [COORD_BITS-1:0]   origin_x_i,
  input  logic signed [COORD_BITS-1:0]   origin_y_i,
  input  logic signed [COORD_BITS-1:0]   origin_z_i,
  input  logic signed [COORD_BITS-1:0]   dir_x_i,
  input  logic signed [COORD_BITS-1:0]   dir_y_i,
  input  logic signed [COORD_BITS-1:0]   dir_z_i,
  input  logic signed [COORD_BITS-1:0]   t_min_i,
  input  logic signed [COORD_BITS-1:0]   t_max_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           hit_o,
  output logic signed [COORD_BITS-1:0]   hit_t_o,
  output logic signed [COORD_BITS-1:0]   point_x_o,
  output logic signed [COORD_BITS-1:0]   point_y_o,
  output logic signed [COORD_BITS-1:0]   point_z_o,
  output logic signed [COORD_BITS-1:0]   normal_x_o,
  output logic signed [COORD_BITS-1:0]   normal_y_o,
  output logic signed [COORD_BITS-1:0]   normal_z_o,
  output logic [rsi_pkg::MAT_W-1:0]      hit_material_o
);

  import rsi_pkg::*;

  localparam int CW  = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int OCW = CW + 1;
  localparam int AW  = 2 * CW;
  localparam int BHW = 2 * CW + 3;
  localparam int CCW = 2 * CW + 4;
  localparam int DSW = 4 * CW + 4;
  localparam int RW  = 2 * CW + 2;
  localparam int SMW = 2 * CW + 4;
  localparam int NW  = SMW + F;
  localparam int QW  = NW + 1;
  localparam int PW  = 2 * CW + 1;
  localparam int NNW = CW + 1 + F;
  localparam int NQW = NNW + 1;
  localparam int RDW = CW - 1;
  localparam int LB  = CW + 2;

  typedef struct packed {
    logic                  miss;
    logic [AW-1:0]         a;
    logic [BHW-1:0]        bh;
    logic [2:0][CW-1:0]    o;
    logic [2:0][CW-1:0]    d;
    logic [CW-1:0]         tmin;
    logic [CW-1:0]         tmax;
  } sq_side_t;

  typedef struct packed {
    logic                  miss;
    logic [2:0][CW-1:0]    o;
    logic [2:0][CW-1:0]    d;
    logic [CW-1:0]         tmin;
    logic [CW-1:0]         tmax;
  } dv_side_t;

  typedef struct packed {
    logic                  hit;
    logic [CW-1:0]         t;
    logic [2:0][CW-1:0]    p;
  } nm_side_t;

  localparam int SQSW = $bits(sq_side_t);
  localparam int DVSW = $bits(dv_side_t);
  localparam int NMSW = $bits(nm_side_t);

  function automatic logic [CW-1:0] sat_pt(input logic [PW-1:0] v);
    if (v[PW-1:CW-1] == {(PW-CW+1){v[PW-1]}}) return v[CW-1:0];
    return v[PW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  function automatic logic [CW-1:0] sat_nq(input logic [NQW-1:0] v);
    if (v[NQW-1:CW-1] == {(NQW-CW+1){v[NQW-1]}}) return v[CW-1:0];
    return v[NQW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  // configuration
  logic signed [CW-1:0] cen_q [3];
  logic [RDW-1:0]       rad_q;
  logic [MAT_W-1:0]     mat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_q[0] <= '0;
      cen_q[1] <= '0;
      cen_q[2] <= '0;
      rad_q    <= RDW'(1) << F;
      mat_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CENTER_X: cen_q[0] <= cfg_data_i;
        CFG_CENTER_Y: cen_q[1] <= cfg_data_i;
        CFG_CENTER_Z: cen_q[2] <= cfg_data_i;
        CFG_RADIUS:   rad_q    <= cfg_data_i[RDW-1:0];
        CFG_MATERIAL: mat_q    <= cfg_data_i[MAT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  logic signed [CW-1:0] o_in [3];
  logic signed [CW-1:0] d_in [3];
  assign o_in[0] = origin_x_i;
  assign o_in[1] = origin_y_i;
  assign o_in[2] = origin_z_i;
  assign d_in[0] = dir_x_i;
  assign d_in[1] = dir_y_i;
  assign d_in[2] = dir_z_i;

  // stages 1..4, sm and 5: dot products and discriminant, wide squares split into partial products
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, sm_valid_q, s5_valid_q;
  logic signed [CW-1:0]    s1_o_q [3];
  logic signed [CW-1:0]    s1_d_q [3];
  logic signed [OCW-1:0]   s1_oc_q [3];
  logic signed [CW-1:0]    s1_tmin_q, s1_tmax_q;
  logic signed [CW-1:0]    s2_o_q [3];
  logic signed [CW-1:0]    s2_d_q [3];
  logic signed [2*CW-1:0]  s2_dd_q [3];
  logic signed [2*CW:0]    s2_dob_q [3];
  logic signed [2*OCW-1:0] s2_oo_q [3];
  logic [2*RDW-1:0]        s2_rr_q;
  logic signed [CW-1:0]    s2_tmin_q, s2_tmax_q;
  logic signed [CW-1:0]    s3_o_q [3];
  logic signed [CW-1:0]    s3_d_q [3];
  logic [AW-1:0]           s3_a_q;
  logic signed [BHW-1:0]   s3_bh_q;
  logic signed [CCW-1:0]   s3_c_q;
  logic signed [CW-1:0]    s3_tmin_q, s3_tmax_q;
  logic signed [CW:0]      bh_h;
  logic [LB-1:0]           bh_l;
  logic [CW-1:0]           a_h, a_l;
  logic signed [CW+1:0]    c_h;
  logic [LB-1:0]           c_l;
  logic signed [CW-1:0]    s4_o_q [3];
  logic signed [CW-1:0]    s4_d_q [3];
  logic [AW-1:0]           s4_a_q;
  logic signed [BHW-1:0]   s4_bh_q;
  logic signed [2*CW+1:0]  s4_bhh_q;
  logic signed [2*CW+3:0]  s4_bhm_q;
  logic [2*CW+3:0]         s4_bll_q;
  logic signed [2*CW+2:0]  s4_ahh_q, s4_alh_q;
  logic [2*CW+1:0]         s4_ahl_q, s4_all_q;
  logic signed [CW-1:0]    s4_tmin_q, s4_tmax_q;
  logic signed [CW-1:0]    sm_o_q [3];
  logic signed [CW-1:0]    sm_d_q [3];
  logic [AW-1:0]           sm_a_q;
  logic signed [BHW-1:0]   sm_bh_q;
  logic signed [DSW-1:0]   sm_bb_q, sm_ac_q;
  logic signed [CW-1:0]    sm_tmin_q, sm_tmax_q;
  logic signed [DSW-1:0]   s5_disc_q;
  sq_side_t                s5_side_q;

  always_comb begin
    bh_h = s3_bh_q[BHW-1:LB];
    bh_l = s3_bh_q[LB-1:0];
    a_h  = s3_a_q[AW-1:CW];
    a_l  = s3_a_q[CW-1:0];
    c_h  = s3_c_q[CCW-1:LB];
    c_l  = s3_c_q[LB-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_o_q[i]   <= o_in[i];
        s1_d_q[i]   <= d_in[i];
        s1_oc_q[i]  <= OCW'(cen_q[i]) - OCW'(o_in[i]);
        s2_o_q[i]   <= s1_o_q[i];
        s2_d_q[i]   <= s1_d_q[i];
        s2_dd_q[i]  <= s1_d_q[i] * s1_d_q[i];
        s2_dob_q[i] <= s1_d_q[i] * s1_oc_q[i];
        s2_oo_q[i]  <= s1_oc_q[i] * s1_oc_q[i];
        s3_o_q[i]   <= s2_o_q[i];
        s3_d_q[i]   <= s2_d_q[i];
        s4_o_q[i]   <= s3_o_q[i];
        s4_d_q[i]   <= s3_d_q[i];
        sm_o_q[i]   <= s4_o_q[i];
        sm_d_q[i]   <= s4_d_q[i];
        s5_side_q.o[i] <= sm_o_q[i];
        s5_side_q.d[i] <= sm_d_q[i];
      end
      s1_tmin_q <= t_min_i;
      s1_tmax_q <= t_max_i;
      s2_rr_q   <= rad_q * rad_q;
      s2_tmin_q <= s1_tmin_q;
      s2_tmax_q <= s1_tmax_q;
      s3_a_q    <= AW'(s2_dd_q[0]) + AW'(s2_dd_q[1]) + AW'(s2_dd_q[2]);
      s3_bh_q   <= BHW'(s2_dob_q[0]) + BHW'(s2_dob_q[1]) + BHW'(s2_dob_q[2]);
      s3_c_q    <= CCW'(s2_oo_q[0]) + CCW'(s2_oo_q[1]) + CCW'(s2_oo_q[2])
                   - CCW'($signed({1'b0, s2_rr_q}));
      s3_tmin_q <= s2_tmin_q;
      s3_tmax_q <= s2_tmax_q;
      s4_a_q    <= s3_a_q;
      s4_bh_q   <= s3_bh_q;
      s4_bhh_q  <= bh_h * bh_h;
      s4_bhm_q  <= bh_h * $signed({1'b0, bh_l});
      s4_bll_q  <= bh_l * bh_l;
      s4_ahh_q  <= $signed({1'b0, a_h}) * c_h;
      s4_ahl_q  <= a_h * c_l;
      s4_alh_q  <= $signed({1'b0, a_l}) * c_h;
      s4_all_q  <= a_l * c_l;
      s4_tmin_q <= s3_tmin_q;
      s4_tmax_q <= s3_tmax_q;
      sm_a_q    <= s4_a_q;
      sm_bh_q   <= s4_bh_q;
      sm_bb_q   <= (DSW'(s4_bhh_q) << (2*LB)) + (DSW'(s4_bhm_q) << (LB+1))
                   + DSW'(s4_bll_q);
      sm_ac_q   <= (DSW'(s4_ahh_q) << (CW+LB)) + (DSW'(s4_ahl_q) << CW)
                   + (DSW'(s4_alh_q) << LB) + DSW'(s4_all_q);
      sm_tmin_q <= s4_tmin_q;
      sm_tmax_q <= s4_tmax_q;
      s5_disc_q <= sm_bb_q - sm_ac_q;
      s5_side_q.miss <= (sm_a_q == '0);
      s5_side_q.a    <= sm_a_q;
      s5_side_q.bh   <= sm_bh_q;
      s5_side_q.tmin <= sm_tmin_q;
      s5_side_q.tmax <= sm_tmax_q;
    end
  end

  // square root row
  logic              sq_valid [RW+1];
  logic [RW+1:0]     sq_rem   [RW+1];
  logic [2*RW-1:0]   sq_rad   [RW+1];
  logic [RW-1:0]     sq_root  [RW+1];
  logic [SQSW-1:0]   sq_side  [RW+1];
  sq_side_t          sq_in_side;
  sq_side_t          sq_out_side;

  always_comb begin
    sq_in_side      = s5_side_q;
    sq_in_side.miss = s5_side_q.miss || s5_disc_q[DSW-1];
  end

  assign sq_valid[0] = s5_valid_q;
  assign sq_rem[0]   = '0;
  assign sq_rad[0]   = s5_disc_q;
  assign sq_root[0]  = '0;
  assign sq_side[0]  = sq_in_side;

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    rsi_sqrt_cell #(.RW(RW), .SW(SQSW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(sq_valid[k]),
      .rem_i  (sq_rem[k]),
      .rad_i  (sq_rad[k]),
      .root_i (sq_root[k]),
      .side_i (sq_side[k]),
      .valid_o(sq_valid[k+1]),
      .rem_o  (sq_rem[k+1]),
      .rad_o  (sq_rad[k+1]),
      .root_o (sq_root[k+1]),
      .side_o (sq_side[k+1])
    );
  end

  assign sq_out_side = sq_side_t'(sq_side[RW]);

  // stage 6: root numerators
  logic                   s6_valid_q;
  logic [1:0][NW-1:0]     s6_num_q;
  logic [AW-1:0]          s6_a_q;
  dv_side_t               s6_side_q;
  logic signed [RW:0]     s_ext;
  logic signed [SMW-1:0]  sum_lo, sum_hi;

  always_comb begin
    s_ext  = $signed({1'b0, sq_root[RW]});
    sum_lo = SMW'($signed(sq_out_side.bh)) - SMW'(s_ext);
    sum_hi = SMW'($signed(sq_out_side.bh)) + SMW'(s_ext);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_num_q[0]    <= {sum_lo, {F{1'b0}}};
      s6_num_q[1]    <= {sum_hi, {F{1'b0}}};
      s6_a_q         <= sq_out_side.a;
      s6_side_q.miss <= sq_out_side.miss;
      s6_side_q.o    <= sq_out_side.o;
      s6_side_q.d    <= sq_out_side.d;
      s6_side_q.tmin <= sq_out_side.tmin;
      s6_side_q.tmax <= sq_out_side.tmax;
    end
  end

  logic               dv_valid;
  logic [1:0][NW:0]   dv_quo;
  logic [DVSW-1:0]    dv_side_raw;
  dv_side_t           dv_side;

  rsi_div_chain #(.LANES(2), .NW(NW), .DW(AW), .SW(DVSW)) u_root_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s6_valid_q),
    .num_i  (s6_num_q),
    .den_i  (s6_a_q),
    .side_i (s6_side_q),
    .valid_o(dv_valid),
    .quo_o  (dv_quo),
    .side_o (dv_side_raw)
  );

  assign dv_side = dv_side_t'(dv_side_raw);

  // stage 7: pick the root inside the interval
  logic signed [QW-1:0] q_near, q_far, tmin_x, tmax_x;
  logic                 in_near, in_far;

  always_comb begin
    q_near  = $signed(dv_quo[0]);
    q_far   = $signed(dv_quo[1]);
    tmin_x  = QW'($signed(dv_side.tmin));
    tmax_x  = QW'($signed(dv_side.tmax));
    in_near = (q_near >= tmin_x) && (q_near <= tmax_x);
    in_far  = (q_far >= tmin_x) && (q_far <= tmax_x);
  end

  logic                  s7_valid_q, s8_valid_q, s9_valid_q, s10_valid_q;
  logic                  s7_hit_q, s8_hit_q, s9_hit_q, s10_hit_q;
  logic signed [CW-1:0]  s7_t_q, s8_t_q, s9_t_q, s10_t_q;
  logic signed [CW-1:0]  s7_o_q [3];
  logic signed [CW-1:0]  s7_d_q [3];
  logic signed [CW-1:0]  s8_o_q [3];
  logic signed [2*CW-1:0] s8_prod_q [3];
  logic signed [CW-1:0]  s9_p_q [3];
  nm_side_t              s10_side_q;
  logic [2:0][NNW-1:0]   s10_nn_q;
  logic signed [PW-1:0]  pt_sum [3];
  logic signed [CW:0]    pc_diff [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt_sum[i]  = PW'(s8_o_q[i]) + PW'(s8_prod_q[i] >>> F);
      pc_diff[i] = (CW+1)'(s9_p_q[i]) - (CW+1)'(cen_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_hit_q <= !dv_side.miss && (in_near || in_far);
      s7_t_q   <= in_near ? q_near[CW-1:0] : q_far[CW-1:0];
      s8_hit_q <= s7_hit_q;
      s8_t_q   <= s7_t_q;
      s9_hit_q <= s8_hit_q;
      s9_t_q   <= s8_t_q;
      s10_side_q.hit <= s9_hit_q;
      s10_side_q.t   <= s9_t_q;
      for (int i = 0; i < 3; i++) begin
        s7_o_q[i]       <= dv_side.o[i];
        s7_d_q[i]       <= dv_side.d[i];
        s8_o_q[i]       <= s7_o_q[i];
        s8_prod_q[i]    <= s7_d_q[i] * s7_t_q;
        s9_p_q[i]       <= sat_pt(pt_sum[i]);
        s10_side_q.p[i] <= s9_p_q[i];
        s10_nn_q[i]     <= {pc_diff[i], {F{1'b0}}};
      end
    end
  end

  // normal division by radius
  logic                nm_valid;
  logic [2:0][NNW:0]   nm_quo;
  logic [NMSW-1:0]     nm_side_raw;
  nm_side_t            nm_side;

  rsi_div_chain #(.LANES(3), .NW(NNW), .DW(RDW), .SW(NMSW)) u_norm_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s10_valid_q),
    .num_i  (s10_nn_q),
    .den_i  (rad_q),
    .side_i (s10_side_q),
    .valid_o(nm_valid),
    .quo_o  (nm_quo),
    .side_o (nm_side_raw)
  );

  assign nm_side = nm_side_t'(nm_side_raw);

  logic                 hit_q;
  logic [CW-1:0]        t_q;
  logic [2:0][CW-1:0]   p_q;
  logic [2:0][CW-1:0]   n_q;
  logic [MAT_W-1:0]     mat_out_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q     <= nm_side.hit;
      t_q       <= nm_side.hit ? nm_side.t : '0;
      mat_out_q <= nm_side.hit ? mat_q : '0;
      for (int i = 0; i < 3; i++) begin
        p_q[i] <= nm_side.hit ? nm_side.p[i] : '0;
        n_q[i] <= (nm_side.hit && rad_q != '0) ? sat_nq(nm_quo[i]) : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      sm_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      s6_valid_q  <= 1'b0;
      s7_valid_q  <= 1'b0;
      s8_valid_q  <= 1'b0;
      s9_valid_q  <= 1'b0;
      s10_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      sm_valid_q  <= s4_valid_q;
      s5_valid_q  <= sm_valid_q;
      s6_valid_q  <= sq_valid[RW];
      s7_valid_q  <= dv_valid;
      s8_valid_q  <= s7_valid_q;
      s9_valid_q  <= s8_valid_q;
      s10_valid_q <= s9_valid_q;
      out_valid_q <= nm_valid;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign hit_t_o        = t_q;
  assign point_x_o      = p_q[0];
  assign point_y_o      = p_q[1];
  assign point_z_o      = p_q[2];
  assign normal_x_o     = n_q[0];
  assign normal_y_o     = n_q[1];
  assign normal_z_o     = n_q[2];
  assign hit_material_o = mat_out_q;

  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready disagrees with output stall");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (hit_t_o == '0 && point_x_o == '0 &&
      normal_x_o == '0 && hit_material_o == '0))
    else $error("miss result carries nonzero fields");

  a_zero_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rad_q == '0) |-> (normal_x_o == '0 && normal_y_o == '0 &&
      normal_z_o == '0))
    else $error("zero radius produced a nonzero normal");

endmodule
